// File: rtl/core/prcv_pkg.sv
// ----------------------------------------------------------------------------
// prcv_pkg: shared types and constants for the profile record CRC validator
// Request and response layouts, configuration layout, status codes and the
// per-word CRC-32 update used by each cell of the CRC chain.
// ----------------------------------------------------------------------------
package prcv_pkg;

	localparam int unsigned WordW      = 32;
	localparam int unsigned NumCrcWords = 9;
	localparam int unsigned CfgIdxW    = 4;
	localparam int unsigned StatusW    = 4;

	localparam logic [WordW-1:0] CrcPoly     = 32'hEDB8_8320;
	localparam logic [WordW-1:0] CrcAllOnes  = 32'hFFFF_FFFF;
	localparam logic [WordW-1:0] RecordBytes = 32'd40;

	// status codes
	localparam logic [StatusW-1:0] StOkUnapproved = 4'd0;
	localparam logic [StatusW-1:0] StOkParams     = 4'd1;
	localparam logic [StatusW-1:0] StOkClosed     = 4'd2;
	localparam logic [StatusW-1:0] StMagic        = 4'd3;
	localparam logic [StatusW-1:0] StLayout       = 4'd4;
	localparam logic [StatusW-1:0] StTarget       = 4'd5;
	localparam logic [StatusW-1:0] StApproval     = 4'd6;
	localparam logic [StatusW-1:0] StRecordCrc    = 4'd7;
	localparam logic [StatusW-1:0] StRuntimeCrc   = 4'd8;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegMagic      = 4'd0;
	localparam logic [CfgIdxW-1:0] RegSchema     = 4'd1;
	localparam logic [CfgIdxW-1:0] RegCfgVersion = 4'd2;
	localparam logic [CfgIdxW-1:0] RegBoard      = 4'd3;
	localparam logic [CfgIdxW-1:0] RegMotor      = 4'd4;
	localparam logic [CfgIdxW-1:0] RegKnownMask  = 4'd5;
	localparam logic [CfgIdxW-1:0] RegClosedBit  = 4'd6;
	localparam logic [CfgIdxW-1:0] RegParamsBit  = 4'd7;

	typedef struct packed {
		logic [WordW-1:0] magic_word;
		logic [WordW-1:0] record_size;
		logic [WordW-1:0] schema_word;
		logic [WordW-1:0] revision;
		logic [WordW-1:0] board_word;
		logic [WordW-1:0] motor_word;
		logic [WordW-1:0] config_version_word;
		logic [WordW-1:0] stored_runtime_crc;
		logic [WordW-1:0] approval_word;
		logic [WordW-1:0] stored_record_crc;
		logic [WordW-1:0] computed_runtime_crc;
	} req_t;

	typedef struct packed {
		logic [StatusW-1:0] status_code;
		logic [WordW-1:0]   record_crc_result;
		logic [WordW-1:0]   revision_echo;
		logic [WordW-1:0]   approval_echo;
		logic [WordW-1:0]   runtime_crc_echo;
	} rsp_t;

	typedef struct packed {
		logic [WordW-1:0] expected_magic;
		logic [WordW-1:0] expected_schema;
		logic [WordW-1:0] expected_config_version;
		logic [WordW-1:0] expected_board;
		logic [WordW-1:0] expected_motor;
		logic [WordW-1:0] known_approval_mask;
		logic [WordW-1:0] closed_loop_bit;
		logic [WordW-1:0] parameters_bit;
	} cfg_t;

	// data handed from one CRC cell to the next
	typedef struct packed {
		logic [WordW-1:0] acc;
		req_t             rec;
	} stage_t;

	// record word by position in the record
	function automatic logic [WordW-1:0] rec_word(input req_t rec, input int unsigned idx);
		logic [WordW-1:0] w;
		case (idx)
			0: w = rec.magic_word;
			1: w = rec.record_size;
			2: w = rec.schema_word;
			3: w = rec.revision;
			4: w = rec.board_word;
			5: w = rec.motor_word;
			6: w = rec.config_version_word;
			7: w = rec.stored_runtime_crc;
			8: w = rec.approval_word;
			default: w = rec.stored_record_crc;
		endcase
		return w;
	endfunction

	// reflected crc-32 over one word, low byte first; flattens to an xor matrix
	function automatic logic [WordW-1:0] crc_word(input logic [WordW-1:0] acc_in,
			input logic [WordW-1:0] w);
		logic [WordW-1:0] acc;
		acc = acc_in ^ w;
		for (int k = 0; k < WordW; k++) begin
			acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
		end
		return acc;
	endfunction

endpackage

// File: rtl/core/prcv_crc_cell.sv
// ----------------------------------------------------------------------------
// prcv_crc_cell: one cell of the CRC chain
// Folds its own record word into the running CRC and hands the record and
// the updated CRC to the next cell whenever the chain advances.
// ----------------------------------------------------------------------------
module prcv_crc_cell #(
	parameter int unsigned WORD_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            valid_in,
	input  prcv_pkg::stage_t d_in,
	output logic            valid_q,
	output prcv_pkg::stage_t d_q
);
	import prcv_pkg::*;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	// crc update and record hand-off
	always_ff @(posedge clk) begin
		if (advance) begin
			d_q.acc <= crc_word(d_in.acc, rec_word(d_in.rec, WORD_IDX));
			d_q.rec <= d_in.rec;
		end
	end

endmodule

// File: rtl/core/prcv_grade.sv
// ----------------------------------------------------------------------------
// prcv_grade: final check stage and response register
// Runs the ordered record checks against the finished CRC and the
// configuration, and holds the response until the receiver takes it.
// ----------------------------------------------------------------------------
module prcv_grade (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             valid_in,
	input  prcv_pkg::stage_t d_in,
	input  prcv_pkg::cfg_t   cfg,
	output logic             rsp_valid,
	output prcv_pkg::rsp_t   rsp
);
	import prcv_pkg::*;

	logic [WordW-1:0]   rec_crc;
	logic [WordW-1:0]   appr;
	logic               closed_set;
	logic               params_set;
	logic [StatusW-1:0] status;

	assign rec_crc    = ~d_in.acc;
	assign appr       = d_in.rec.approval_word;
	assign closed_set = |(appr & cfg.closed_loop_bit);
	assign params_set = |(appr & cfg.parameters_bit);

	// first failing check wins, otherwise grade by approval bits
	always_comb begin
		if (d_in.rec.magic_word != cfg.expected_magic) begin
			status = StMagic;
		end else if (d_in.rec.record_size != RecordBytes ||
				d_in.rec.schema_word != cfg.expected_schema ||
				d_in.rec.revision == '0 ||
				d_in.rec.config_version_word != cfg.expected_config_version) begin
			status = StLayout;
		end else if (d_in.rec.board_word != cfg.expected_board ||
				d_in.rec.motor_word != cfg.expected_motor) begin
			status = StTarget;
		end else if ((|(appr & ~cfg.known_approval_mask)) || (closed_set && !params_set)) begin
			status = StApproval;
		end else if (rec_crc != d_in.rec.stored_record_crc) begin
			status = StRecordCrc;
		end else if (d_in.rec.computed_runtime_crc != d_in.rec.stored_runtime_crc) begin
			status = StRuntimeCrc;
		end else if (closed_set) begin
			status = StOkClosed;
		end else if (params_set) begin
			status = StOkParams;
		end else begin
			status = StOkUnapproved;
		end
	end

	// response occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_in;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.status_code       <= status;
			rsp.record_crc_result <= rec_crc;
			rsp.revision_echo     <= d_in.rec.revision;
			rsp.approval_echo     <= appr;
			rsp.runtime_crc_echo  <= d_in.rec.computed_runtime_crc;
		end
	end

endmodule

// File: rtl/core/profile_record_crc_validator.sv
// ----------------------------------------------------------------------------
// profile_record_crc_validator: profile record CRC and field validator
// A chain of nine CRC cells folds record words 0 to 8 into a CRC-32, one
// word per cell, followed by a check stage that grades the record.
//
// Request channel (req_valid, req_stall, req): one whole profile record and
// the separately computed runtime CRC. Response channel (rsp_valid,
// rsp_stall, rsp): status code, computed record CRC and echoed fields.
// A transfer happens on a clock edge with valid high and stall low.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always
// ready; indexes 0 to 7 select the registers, higher indexes are dropped.
// Write configuration only while no request is in flight.
//
// A request passes the nine CRC cells and then the check stage on its way to
// the response. One request is taken every cycle while the chain is not
// stalled; the rate is set by the cell chain, which moves one stage per cycle.
// When the receiver stalls a held response, the whole chain freezes and
// req_stall rises in the same cycle; requests already inside are kept.
// Reset empties every stage and clears all configuration registers to zero.
// ----------------------------------------------------------------------------
module profile_record_crc_validator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  prcv_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output prcv_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [prcv_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [prcv_pkg::WordW-1:0]      cfg_data
);
	import prcv_pkg::*;

	cfg_t   cfg_q;
	logic   advance;
	logic   valid_c [NumCrcWords+1];
	stage_t data_c  [NumCrcWords+1];

	// chain moves unless a finished response is held by the receiver
	assign advance   = !(rsp_valid && rsp_stall);
	assign req_stall = !advance;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegMagic:      cfg_q.expected_magic          <= cfg_data;
				RegSchema:     cfg_q.expected_schema         <= cfg_data;
				RegCfgVersion: cfg_q.expected_config_version <= cfg_data;
				RegBoard:      cfg_q.expected_board          <= cfg_data;
				RegMotor:      cfg_q.expected_motor          <= cfg_data;
				RegKnownMask:  cfg_q.known_approval_mask     <= cfg_data;
				RegClosedBit:  cfg_q.closed_loop_bit         <= cfg_data;
				RegParamsBit:  cfg_q.parameters_bit          <= cfg_data;
				default: ;
			endcase
		end
	end

	// chain head: crc starts at all ones
	assign valid_c[0]    = req_valid;
	assign data_c[0].acc = CrcAllOnes;
	assign data_c[0].rec = req;

	// crc cells, one record word each
	for (genvar i = 0; i < NumCrcWords; i++) begin : g_cell
		prcv_crc_cell #(
			.WORD_IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid_in(valid_c[i]),
			.d_in    (data_c[i]),
			.valid_q (valid_c[i+1]),
			.d_q     (data_c[i+1])
		);
	end

	// checks and response register
	prcv_grade u_grade (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_in (valid_c[NumCrcWords]),
		.d_in     (data_c[NumCrcWords]),
		.cfg      (cfg_q),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule
